// File: sv/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolation block.
// No dependencies; imported by every other file of the block.
package pli_pkg;

  // Field widths of the beats
  localparam int unsigned PointW = 16;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned CountW = 7;

  // Default table depth
  localparam int unsigned MaxPoints = 64;

  // Divider: 32-bit dividend, 16-bit divisor, 16 quotient bits
  localparam int unsigned ProdW  = 2 * PointW;
  localparam int unsigned DivCntW = $clog2(PointW + 1);

  // Action codes of an input beat
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // One breakpoint pair as stored in the table
  typedef struct packed {
    logic [PointW-1:0] in_pt;
    logic [PointW-1:0] out_pt;
  } pli_entry_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } pli_div_stat_t;

endpackage

// File: sv/pli_table.sv
// Breakpoint pair memory: one write port, one registered read port.
// Depends on pli_pkg for the entry type.
module pli_table #(
  parameter int unsigned DEPTH = pli_pkg::MaxPoints,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [AW-1:0]          wr_addr_i,
  input  pli_pkg::pli_entry_t    wr_data_i,
  input  logic [AW-1:0]          rd_addr_i,
  output pli_pkg::pli_entry_t    rd_data_o
);
  import pli_pkg::*;

  pli_entry_t mem_q [DEPTH];
  pli_entry_t rd_data_q;

  // Store a pair on a write beat
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Register the read data every cycle
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/pli_div.sv
// Restoring divider, one quotient bit per cycle while busy; start is ignored while busy.
// Depends on pli_pkg. Requires the upper half of the dividend below the divisor.
module pli_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pli_pkg::ProdW-1:0]     dividend_i,
  input  logic [pli_pkg::PointW-1:0]    divisor_i,
  output logic [pli_pkg::PointW-1:0]    quotient_o,
  output pli_pkg::pli_div_stat_t        stat_o
);
  import pli_pkg::*;

  logic [PointW-1:0]  rem_q, rem_d;
  logic [PointW-1:0]  quo_q, quo_d;
  logic [PointW-1:0]  dsr_q, dsr_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [PointW:0]    trial;
  logic [PointW:0]    diff;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[PointW-1]};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i && !busy_q) begin
      rem_d  = dividend_i[ProdW-1:PointW];
      quo_d  = dividend_i[PointW-1:0];
      dsr_d  = divisor_i;
      cnt_d  = DivCntW'(PointW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[PointW]) begin
        rem_d = diff[PointW-1:0];
        quo_d = {quo_q[PointW-2:0], 1'b1};
      end else begin
        rem_d = trial[PointW-1:0];
        quo_d = {quo_q[PointW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers need no reset
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: sv/piecewise_linear_lut_interp.sv
// Top level: sequencer, breakpoint memory and divider of the interpolator.
// Depends on pli_pkg, pli_table and pli_div.
//
//  channel | signals                                           | dir
//  --------+---------------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, action, entry_index,       | in
//          | in_point, out_point, sample                       |
//  out     | out_valid_o/out_ready_i, result, no_segment       | out
//  cfg     | cfg_valid_i/cfg_ready_o, points_in_use            | in
//
// A write beat is stored as it is accepted. A lookup scans S segments, S up to
// points_in_use - 1, one memory read per segment; a bracketing segment then goes
// through the multiply and, unless zero wide, the 16-step divider. Clamped lookups skip both.
// Reset is asynchronous, active low; table contents are kept undefined until written.
// A result waits in the output register; the block takes new beats meanwhile and
// stalls only when a second result is ready before the first is taken.
module piecewise_linear_lut_interp #(
  parameter int unsigned MAX_POINTS = pli_pkg::MaxPoints
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [pli_pkg::SlotW-1:0]     entry_index_i,
  input  logic [pli_pkg::PointW-1:0]    in_point_i,
  input  logic [pli_pkg::PointW-1:0]    out_point_i,
  input  logic [pli_pkg::PointW-1:0]    sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [pli_pkg::PointW-1:0]    result_o,
  output logic                          no_segment_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pli_pkg::CountW-1:0]    points_in_use_i
);
  import pli_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_FIRST, ST_LAST, ST_SCAN, ST_MUL, ST_DIVS, ST_DIVW, ST_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [PointW-1:0] sample_q, sample_d;
  pli_entry_t        lo_q, lo_d;
  pli_entry_t        hi_q, hi_d;
  logic [AW-1:0]     hi_idx_q, hi_idx_d;
  logic [AW-1:0]     last_idx_q, last_idx_d;
  logic              neg_q, neg_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [PointW-1:0] res_q, res_d;
  logic              nseg_q, nseg_d;
  logic              out_valid_q, out_valid_d;
  logic [PointW-1:0] result_q, result_d;
  logic              no_seg_q, no_seg_d;

  logic              in_acc;
  logic              tbl_wr_en;
  pli_entry_t        tbl_wr_data;
  logic [AW-1:0]     rd_addr;
  pli_entry_t        rd_data;
  logic              div_start;
  logic [PointW-1:0] div_quo;
  pli_div_stat_t     div_st;
  logic [PointW-1:0] seg_width;
  logic [PointW-1:0] dx;
  logic [PointW-1:0] dy_mag;
  logic [31:0]       cnt_ext;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;

  // Store a pair on a write beat; drop slots beyond the table
  assign tbl_wr_en = in_acc && (action_i == ACT_WRITE) &&
                     (32'(entry_index_i) < 32'(MAX_POINTS));
  assign tbl_wr_data.in_pt  = in_point_i;
  assign tbl_wr_data.out_pt = out_point_i;

  pli_table #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (AW'(entry_index_i)),
    .wr_data_i (tbl_wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (seg_width),
    .quotient_o (div_quo),
    .stat_o     (div_st)
  );

  // Segment geometry from the bracketing pair
  assign seg_width = hi_q.in_pt - lo_q.in_pt;
  assign dx        = sample_q - lo_q.in_pt;
  assign dy_mag    = (hi_q.out_pt < lo_q.out_pt) ? (lo_q.out_pt - hi_q.out_pt)
                                                 : (hi_q.out_pt - lo_q.out_pt);

  // Clamp the written count to between 2 and the table depth and derive the last index
  always_comb begin
    cnt_ext    = 32'(points_in_use_i);
    if (cnt_ext < 32'd2) begin
      cnt_ext = 32'd2;
    end else if (cnt_ext > 32'(MAX_POINTS)) begin
      cnt_ext = 32'(MAX_POINTS);
    end
    last_idx_d = last_idx_q;
    if (cfg_valid_i && cfg_ready_o) begin
      last_idx_d = AW'(cnt_ext - 32'd1);
    end
  end

  // Sequencer: clamp checks, segment scan, multiply, divide, hand off
  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    hi_idx_d    = hi_idx_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    res_d       = res_q;
    nseg_d      = nseg_q;
    rd_addr     = '0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    result_d    = result_q;
    no_seg_d    = no_seg_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (action_i == ACT_LOOKUP)) begin
          sample_d = sample_i;
          state_d  = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (sample_q <= rd_data.in_pt) begin
          res_d   = rd_data.out_pt;
          nseg_d  = 1'b0;
          state_d = ST_OUT;
        end else begin
          lo_d    = rd_data;
          rd_addr = last_idx_q;
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (sample_q >= rd_data.in_pt) begin
          res_d   = rd_data.out_pt;
          nseg_d  = 1'b0;
          state_d = ST_OUT;
        end else begin
          rd_addr  = AW'(1);
          hi_idx_d = AW'(1);
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((sample_q >= lo_q.in_pt) && (sample_q <= rd_data.in_pt)) begin
          hi_d    = rd_data;
          state_d = ST_MUL;
        end else if (hi_idx_q == last_idx_q) begin
          res_d   = '0;
          nseg_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          lo_d     = rd_data;
          hi_idx_d = hi_idx_q + 1'b1;
          rd_addr  = hi_idx_q + 1'b1;
        end
      end
      ST_MUL: begin
        nseg_d = 1'b0;
        if (seg_width == '0) begin
          res_d   = lo_q.out_pt;
          state_d = ST_OUT;
        end else begin
          prod_d  = ProdW'(dx) * ProdW'(dy_mag);
          neg_d   = (hi_q.out_pt < lo_q.out_pt);
          state_d = ST_DIVS;
        end
      end
      ST_DIVS: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_st.done) begin
          res_d   = neg_q ? (lo_q.out_pt - div_quo) : (lo_q.out_pt + div_quo);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          result_d    = res_q;
          no_seg_d    = nseg_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state, configuration and the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_idx_q  <= AW'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_idx_q  <= last_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    hi_idx_q <= hi_idx_d;
    neg_q    <= neg_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
    nseg_q   <= nseg_d;
    result_q <= result_d;
    no_seg_q <= no_seg_d;
  end

  assign out_valid_o  = out_valid_q;
  assign result_o     = result_q;
  assign no_segment_o = no_seg_q;

`ifndef NO_ASSERTIONS
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (action_i == ACT_LOOKUP) |=> !in_ready_o)
    else $error("lookup accepted but block still ready");

  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr_en |-> (state_q == ST_IDLE))
    else $error("table written during a lookup");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == ST_DIVW))
    else $error("divider finished outside the wait state");

  a_noseg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && no_segment_o |-> (result_o == '0))
    else $error("no segment flagged with a nonzero result");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) && (!out_valid_q || out_ready_i) |=> out_valid_o)
    else $error("finished result not loaded into the output register");
`endif

endmodule
